/* hdl/vlcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line counter sequencer package
// Widths, register indexes, codes and bundle types shared by the sequencer,
// its line state unit and its port checker.
// ----------------------------------------------------------------------------
package vlcs_pkg;

	// Field widths.
	localparam int unsigned LINE_W     = 9;
	localparam int unsigned MC_W       = 10;
	localparam int unsigned ROW_W      = 3;
	localparam int unsigned BLINK_W    = 5;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SRC_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 9;

	// Default number of text columns per character row.
	localparam int unsigned TEXT_COLUMNS_DEF = 40;

	// Reset values of the configuration registers.
	localparam logic [LINE_W-1:0] FIRST_VISIBLE_RST = '0;
	localparam logic [LINE_W-1:0] LAST_VISIBLE_RST  = '1;
	localparam logic [LINE_W-1:0] DMA_START_RST     = '0;

	// Row counter values at which the pointers are latched.
	localparam logic [ROW_W-1:0] ROW_COLOUR_LATCH = 3'd6;
	localparam logic [ROW_W-1:0] ROW_LAST         = 3'd7;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_VISIBLE = 2'd0,
		REG_LAST_VISIBLE  = 2'd1,
		REG_DMA_START     = 2'd2,
		REG_IDLE_SELECT   = 2'd3
	} cfg_reg_t;

	// Source of the idle fetch byte.
	typedef enum logic [SRC_W-1:0] {
		SRC_NONE = 2'd0,
		SRC_LOW  = 2'd1,
		SRC_HIGH = 2'd2
	} idle_src_t;

	typedef struct packed {
		logic [LINE_W-1:0] first_visible_line;
		logic [LINE_W-1:0] last_visible_line;
		logic [LINE_W-1:0] dma_start_line;
		logic              idle_source_select;
	} cfg_t;

	typedef struct packed {
		logic [LINE_W-1:0] line_number;
		logic              bad_line_seen;
		logic              display_blanked;
		logic              force_display;
		logic [BYTE_W-1:0] idle_byte_low_bank;
		logic [BYTE_W-1:0] idle_byte_high_bank;
	} item_t;

	typedef struct packed {
		logic [MC_W-1:0]   matrix_counter;
		logic [MC_W-1:0]   row_pointer;
		logic [MC_W-1:0]   colour_pointer;
		logic [ROW_W-1:0]  row_counter;
		logic              idle_flag;
		logic              cursor_on;
		logic              bad_lines_allowed;
		idle_src_t         idle_source;
		logic [BYTE_W-1:0] idle_byte;
		logic              frame_start;
	} result_t;

endpackage

/* hdl/vlcs_line_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line state unit
// Holds the per-frame counters and flags and works out the result of one
// end-of-line event; the state advances when the event is committed.
// ----------------------------------------------------------------------------
module vlcs_line_state #(
	parameter int unsigned TEXT_COLUMNS = vlcs_pkg::TEXT_COLUMNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              commit,
	input  vlcs_pkg::item_t   item,
	input  vlcs_pkg::cfg_t    cfg,
	output vlcs_pkg::result_t result
);
	import vlcs_pkg::*;

	localparam logic [STEP_W-1:0] STEP_VAL = STEP_W'(TEXT_COLUMNS);

	logic [MC_W-1:0]    mc_q, mc_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic [MC_W-1:0]    row_latch_q, row_latch_d;
	logic [MC_W-1:0]    colour_latch_q, colour_latch_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic               idle_q, idle_d;
	logic [BLINK_W-1:0] blink_q, blink_d;
	logic               ble_q, ble_d;
	logic               frame;
	logic               visible;

	// Next state for the event held in the input register.
	always_comb begin
		mc_d           = mc_q;
		step_d         = step_q;
		row_latch_d    = row_latch_q;
		colour_latch_d = colour_latch_q;
		row_d          = row_q;
		idle_d         = idle_q;
		blink_d        = blink_q;
		ble_d          = ble_q;
		frame   = (item.line_number == '0);
		visible = (item.line_number >= cfg.first_visible_line) &&
			(item.line_number <= cfg.last_visible_line);

		// Top of frame clears the matrix counters and steps the blink phase.
		if (frame) begin
			mc_d           = '0;
			row_latch_d    = '0;
			colour_latch_d = '0;
			blink_d        = blink_q + BLINK_W'(1);
		end

		// Visible band: counter advance, pointer latches and row stepping.
		if (visible) begin
			if (!idle_q) begin
				mc_d = mc_d + MC_W'(step_q);
			end
			step_d = STEP_VAL;
			if (row_q == ROW_COLOUR_LATCH) begin
				colour_latch_d = mc_d;
			end
			if (row_q == ROW_LAST) begin
				row_latch_d = mc_d;
				idle_d      = 1'b1;
			end
			if (!idle_d || item.bad_line_seen) begin
				row_d  = row_q + ROW_W'(1);
				idle_d = 1'b0;
			end
			if (item.force_display) begin
				idle_d = 1'b0;
			end
		end

		// Bad lines are enabled for the frame when the screen is not blanked.
		if (item.line_number == cfg.dma_start_line) begin
			ble_d = !item.display_blanked;
		end
	end

	// Result fields, including the idle fetch byte choice.
	always_comb begin
		result.matrix_counter    = mc_d;
		result.row_pointer       = row_latch_d;
		result.colour_pointer    = colour_latch_d;
		result.row_counter       = row_d;
		result.idle_flag         = idle_d;
		result.cursor_on         = blink_d[BLINK_W-1];
		result.bad_lines_allowed = ble_d;
		result.frame_start       = frame;
		result.idle_source       = SRC_NONE;
		result.idle_byte         = '0;
		if (idle_d) begin
			if (cfg.idle_source_select) begin
				result.idle_source = SRC_LOW;
				result.idle_byte   = item.idle_byte_low_bank;
			end else begin
				result.idle_source = SRC_HIGH;
				result.idle_byte   = item.idle_byte_high_bank;
			end
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q           <= '0;
			step_q         <= '0;
			row_latch_q    <= '0;
			colour_latch_q <= '0;
			row_q          <= '0;
			idle_q         <= 1'b0;
			blink_q        <= '0;
			ble_q          <= 1'b0;
		end else if (commit) begin
			mc_q           <= mc_d;
			step_q         <= step_d;
			row_latch_q    <= row_latch_d;
			colour_latch_q <= colour_latch_d;
			row_q          <= row_d;
			idle_q         <= idle_d;
			blink_q        <= blink_d;
			ble_q          <= ble_d;
		end
	end

endmodule

/* hdl/video_line_counter_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line counter sequencer
// Steps the video matrix counter, row counter, idle flag, pointer latches,
// cursor blink phase and bad-line enable once per end-of-line event.
// ----------------------------------------------------------------------------
// One end-of-line event is accepted every clock cycle while input stall is low;
// its result passes through the input register and the result register. Both
// registers advance together, so a stalled result holds the event behind it
// in the input register and input stall rises only when both are full. The
// line state is updated as an event moves from the input register to the
// result register, so back-to-back events see each other's effects.
// Configuration writes take effect at once and are meant for idle periods.
module video_line_counter_sequencer #(
	parameter int unsigned TEXT_COLUMNS = vlcs_pkg::TEXT_COLUMNS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_write_enable,
	input  logic [vlcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vlcs_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Event input channel.
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [vlcs_pkg::LINE_W-1:0]        line_number,
	input  logic                               bad_line_seen,
	input  logic                               display_blanked,
	input  logic                               force_display,
	input  logic [vlcs_pkg::BYTE_W-1:0]        idle_byte_low_bank,
	input  logic [vlcs_pkg::BYTE_W-1:0]        idle_byte_high_bank,
	// Result output channel.
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [vlcs_pkg::MC_W-1:0]          matrix_counter,
	output logic [vlcs_pkg::MC_W-1:0]          row_pointer,
	output logic [vlcs_pkg::MC_W-1:0]          colour_pointer,
	output logic [vlcs_pkg::ROW_W-1:0]         row_counter,
	output logic                               idle_flag,
	output logic                               cursor_on,
	output logic                               bad_lines_allowed,
	output logic [vlcs_pkg::SRC_W-1:0]         idle_source,
	output logic [vlcs_pkg::BYTE_W-1:0]        idle_byte,
	output logic                               frame_start
);
	import vlcs_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	result_t result_d;
	logic    valid_s2;
	logic    load_s2;
	logic    load_s1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_visible_line <= FIRST_VISIBLE_RST;
			cfg_q.last_visible_line  <= LAST_VISIBLE_RST;
			cfg_q.dma_start_line     <= DMA_START_RST;
			cfg_q.idle_source_select <= 1'b0;
		end else if (cfg_write_enable) begin
			case (cfg_reg_t'(cfg_index))
				REG_FIRST_VISIBLE: cfg_q.first_visible_line <= cfg_data[LINE_W-1:0];
				REG_LAST_VISIBLE:  cfg_q.last_visible_line  <= cfg_data[LINE_W-1:0];
				REG_DMA_START:     cfg_q.dma_start_line     <= cfg_data[LINE_W-1:0];
				REG_IDLE_SELECT:   cfg_q.idle_source_select <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow: the result register loads when empty or being drained.
	assign load_s2  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s2 || !valid_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1 <= '{line_number, bad_line_seen, display_blanked, force_display,
				idle_byte_low_bank, idle_byte_high_bank};
		end
	end

	// Line state and result logic.
	vlcs_line_state #(
		.TEXT_COLUMNS(TEXT_COLUMNS)
	) u_line_state (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (valid_s1 && load_s2),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result_d)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			result_s2 <= result_d;
		end
	end

	assign out_valid         = valid_s2;
	assign matrix_counter    = result_s2.matrix_counter;
	assign row_pointer       = result_s2.row_pointer;
	assign colour_pointer    = result_s2.colour_pointer;
	assign row_counter       = result_s2.row_counter;
	assign idle_flag         = result_s2.idle_flag;
	assign cursor_on         = result_s2.cursor_on;
	assign bad_lines_allowed = result_s2.bad_lines_allowed;
	assign idle_source       = result_s2.idle_source;
	assign idle_byte         = result_s2.idle_byte;
	assign frame_start       = result_s2.frame_start;

endmodule

/* hdl/vlcs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line counter sequencer port checker
// Watches the result channel of the sequencer and flags inconsistent
// results; bound to the top level below.
// ----------------------------------------------------------------------------
module vlcs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [vlcs_pkg::MC_W-1:0]       matrix_counter,
	input logic [vlcs_pkg::ROW_W-1:0]      row_counter,
	input logic                            idle_flag,
	input logic [vlcs_pkg::SRC_W-1:0]      idle_source,
	input logic [vlcs_pkg::BYTE_W-1:0]     idle_byte
);
	import vlcs_pkg::*;

	// A stalled result is held until its transfer.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matrix_counter) &&
		$stable(row_counter) && $stable(idle_source) && $stable(idle_byte))
		else $error("stalled result changed");

	// Outside idle no idle byte is fetched.
	a_no_idle_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !idle_flag |-> idle_source == SRC_NONE && idle_byte == '0)
		else $error("idle byte outside idle state");

	// In idle a bank is always chosen.
	a_idle_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle_flag |-> idle_source == SRC_LOW || idle_source == SRC_HIGH)
		else $error("no idle source in idle state");

endmodule

bind video_line_counter_sequencer vlcs_checker u_vlcs_checker (.*);

/* tb/sv/tb_video_line_counter_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raster line counter sequencer testbench
// Drives end-of-line events through the valid/stall channel, predicts each
// result with a behavioral copy of the line state and checks every result
// transfer field by field. A directed table comes first, then random frames
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_video_line_counter_sequencer;

	import vlcs_pkg::*;

	localparam int unsigned COLUMNS         = TEXT_COLUMNS_DEF;
	localparam int          RESET_CYCLES    = 7;
	localparam int          PIPE_DEPTH      = 4;
	localparam int          TAIL_CYCLES     = 16;
	localparam int          WATCHDOG_LIMIT  = 1000;
	localparam int          PHASES          = 8;
	localparam int          LINES_PER_PHASE = 50;
	localparam int          DIRECTED_COUNT  = 23;

	// Register settings used by the directed table.
	localparam cfg_t CFG_RESET    = '{FIRST_VISIBLE_RST, LAST_VISIBLE_RST, DMA_START_RST, 1'b0};
	localparam cfg_t CFG_BAND     = '{9'd100, 9'd200, 9'd150, 1'b1};
	localparam cfg_t CFG_INVERTED = '{9'd300, 9'd10, 9'd511, 1'b0};
	localparam cfg_t CFG_TOP      = '{9'd511, 9'd511, 9'd511, 1'b1};
	localparam result_t NO_RESULT = '0;

	// One row of the directed table: the setting, the event and an optional
	// result that is obvious from the behavior.
	typedef struct packed {
		cfg_t    setting;
		item_t   line_in;
		logic    typed;
		result_t want;
	} line_case_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_enable = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [LINE_W-1:0]     line_number = '0;
	logic                  bad_line_seen = 1'b0;
	logic                  display_blanked = 1'b0;
	logic                  force_display = 1'b0;
	logic [BYTE_W-1:0]     idle_byte_low_bank = '0;
	logic [BYTE_W-1:0]     idle_byte_high_bank = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [MC_W-1:0]       matrix_counter;
	logic [MC_W-1:0]       row_pointer;
	logic [MC_W-1:0]       colour_pointer;
	logic [ROW_W-1:0]      row_counter;
	logic                  idle_flag;
	logic                  cursor_on;
	logic                  bad_lines_allowed;
	logic [SRC_W-1:0]      idle_source;
	logic [BYTE_W-1:0]     idle_byte;
	logic                  frame_start;

	// Predicted line state and the register values it runs under.
	cfg_t              cfg_now = CFG_RESET;
	logic [MC_W-1:0]   pred_matrix = '0;
	logic [STEP_W-1:0] pred_step = '0;
	logic [MC_W-1:0]   pred_row_ptr = '0;
	logic [MC_W-1:0]   pred_colour_ptr = '0;
	logic [ROW_W-1:0]  pred_row = '0;
	logic              pred_idle = 1'b0;
	logic [BLINK_W-1:0] pred_blink = '0;
	logic              pred_bad_enable = 1'b0;

	result_t expected_results [$];
	int      failures = 0;
	int      lines_sent = 0;
	int      settings_used = 0;
	int      frames_seen = 0;
	int      idle_results = 0;
	int      quiet_cycles = 0;
	logic    calm = 1'b0;

	line_case_t directed_lines [0:DIRECTED_COUNT-1] = '{
		// Frame start right after reset.
		'{CFG_RESET, '{9'd0, 1'b0, 1'b0, 1'b0, 8'h00, 8'hff}, 1'b1,
			'{10'd0, 10'd0, 10'd0, 3'd1, 1'b0, 1'b0, 1'b1, SRC_NONE, 8'h00, 1'b1}},
		// Last line with every flag set.
		'{CFG_RESET, '{9'd511, 1'b1, 1'b1, 1'b1, 8'hff, 8'h00}, 1'b1,
			'{10'd40, 10'd0, 10'd0, 3'd2, 1'b0, 1'b0, 1'b1, SRC_NONE, 8'h00, 1'b0}},
		'{CFG_RESET, '{9'd1, 1'b0, 1'b0, 1'b0, 8'h12, 8'h34}, 1'b0, NO_RESULT},
		'{CFG_RESET, '{9'd2, 1'b0, 1'b1, 1'b0, 8'h56, 8'h78}, 1'b0, NO_RESULT},
		'{CFG_RESET, '{9'd3, 1'b0, 1'b0, 1'b0, 8'h9a, 8'hbc}, 1'b0, NO_RESULT},
		'{CFG_RESET, '{9'd4, 1'b0, 1'b1, 1'b0, 8'hde, 8'hf0}, 1'b0, NO_RESULT},
		// Row six latches the colour pointer.
		'{CFG_RESET, '{9'd5, 1'b0, 1'b0, 1'b0, 8'h11, 8'h22}, 1'b0, NO_RESULT},
		// Row seven latches the row pointer and enters idle.
		'{CFG_RESET, '{9'd6, 1'b0, 1'b0, 1'b0, 8'h5a, 8'ha5}, 1'b1,
			'{10'd280, 10'd280, 10'd240, 3'd7, 1'b1, 1'b0, 1'b1, SRC_HIGH, 8'ha5, 1'b0}},
		'{CFG_RESET, '{9'd7, 1'b0, 1'b0, 1'b0, 8'h33, 8'h44}, 1'b0, NO_RESULT},
		// A forced display leaves idle.
		'{CFG_RESET, '{9'd8, 1'b0, 1'b0, 1'b1, 8'h55, 8'h66}, 1'b0, NO_RESULT},
		'{CFG_RESET, '{9'd9, 1'b0, 1'b0, 1'b0, 8'h77, 8'h88}, 1'b0, NO_RESULT},
		// A bad line leaves idle and steps the row.
		'{CFG_RESET, '{9'd10, 1'b1, 1'b0, 1'b0, 8'h99, 8'haa}, 1'b0, NO_RESULT},
		// Frame start with blanking clears the bad-line enable.
		'{CFG_RESET, '{9'd0, 1'b0, 1'b1, 1'b0, 8'hbb, 8'hcc}, 1'b0, NO_RESULT},
		// Bad line and forced display outside the band are ignored.
		'{CFG_BAND, '{9'd50, 1'b1, 1'b0, 1'b1, 8'h01, 8'h02}, 1'b0, NO_RESULT},
		'{CFG_BAND, '{9'd100, 1'b0, 1'b0, 1'b0, 8'h03, 8'h04}, 1'b0, NO_RESULT},
		'{CFG_BAND, '{9'd150, 1'b0, 1'b0, 1'b0, 8'h05, 8'h06}, 1'b0, NO_RESULT},
		'{CFG_BAND, '{9'd200, 1'b0, 1'b0, 1'b0, 8'h07, 8'h08}, 1'b0, NO_RESULT},
		'{CFG_BAND, '{9'd201, 1'b1, 1'b1, 1'b1, 8'h09, 8'h0a}, 1'b0, NO_RESULT},
		// Inverted band: nothing is visible.
		'{CFG_INVERTED, '{9'd5, 1'b1, 1'b0, 1'b1, 8'h0b, 8'h0c}, 1'b0, NO_RESULT},
		'{CFG_INVERTED, '{9'd0, 1'b0, 1'b0, 1'b0, 8'h0d, 8'h0e}, 1'b0, NO_RESULT},
		'{CFG_INVERTED, '{9'd511, 1'b0, 1'b1, 1'b0, 8'h0f, 8'h10}, 1'b0, NO_RESULT},
		// A band of one line at the top.
		'{CFG_TOP, '{9'd511, 1'b0, 1'b0, 1'b0, 8'hc3, 8'h3c}, 1'b0, NO_RESULT},
		'{CFG_TOP, '{9'd510, 1'b1, 1'b1, 1'b1, 8'h81, 8'h18}, 1'b0, NO_RESULT}
	};

	video_line_counter_sequencer #(.TEXT_COLUMNS(COLUMNS)) u_dut (.*);

	// Free-running clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advances the predicted line state by one event and returns its result.
	function automatic result_t advance_raster(input item_t ev);
		result_t r;
		logic    visible;
		visible = ev.line_number >= cfg_now.first_visible_line &&
			ev.line_number <= cfg_now.last_visible_line;
		if (ev.line_number == '0) begin
			pred_matrix = '0;
			pred_row_ptr = '0;
			pred_colour_ptr = '0;
			pred_blink = pred_blink + BLINK_W'(1);
		end
		if (visible) begin
			if (!pred_idle)
				pred_matrix = pred_matrix + MC_W'(pred_step);
			pred_step = STEP_W'(COLUMNS);
			if (pred_row == ROW_COLOUR_LATCH)
				pred_colour_ptr = pred_matrix;
			if (pred_row == ROW_LAST) begin
				pred_row_ptr = pred_matrix;
				pred_idle = 1'b1;
			end
			if (!pred_idle || ev.bad_line_seen) begin
				pred_row = pred_row + ROW_W'(1);
				pred_idle = 1'b0;
			end
			if (ev.force_display)
				pred_idle = 1'b0;
		end
		if (ev.line_number == cfg_now.dma_start_line)
			pred_bad_enable = !ev.display_blanked;

		r.matrix_counter = pred_matrix;
		r.row_pointer = pred_row_ptr;
		r.colour_pointer = pred_colour_ptr;
		r.row_counter = pred_row;
		r.idle_flag = pred_idle;
		r.cursor_on = pred_blink[BLINK_W-1];
		r.bad_lines_allowed = pred_bad_enable;
		r.idle_source = SRC_NONE;
		r.idle_byte = '0;
		if (pred_idle) begin
			r.idle_source = cfg_now.idle_source_select ? SRC_LOW : SRC_HIGH;
			r.idle_byte = cfg_now.idle_source_select ? ev.idle_byte_low_bank :
				ev.idle_byte_high_bank;
		end
		r.frame_start = (ev.line_number == '0);
		return r;
	endfunction

	// Offers one event and waits for its transfer; the expected result is
	// queued at the edge that accepts it. Valid stays high on return.
	task automatic send_line(input item_t ev, input logic typed, input result_t want);
		result_t r;
		in_valid <= 1'b1;
		line_number <= ev.line_number;
		bad_line_seen <= ev.bad_line_seen;
		display_blanked <= ev.display_blanked;
		force_display <= ev.force_display;
		idle_byte_low_bank <= ev.idle_byte_low_bank;
		idle_byte_high_bank <= ev.idle_byte_high_bank;
		do @(posedge clk); while (in_stall !== 1'b0);
		r = advance_raster(ev);
		if (typed)
			r = want;
		expected_results.push_back(r);
		lines_sent++;
		if (r.frame_start)
			frames_seen++;
		if (r.idle_flag)
			idle_results++;
	endtask

	// Holds the input channel idle for a number of cycles.
	task automatic pause_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stops sending and waits until every result has come out.
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	// Writes all four registers, one per cycle. Spare data bits of the
	// one-bit register carry noise, which the block must mask off.
	task automatic apply_setting(input cfg_t c);
		cfg_write_enable <= 1'b1;
		cfg_index <= REG_FIRST_VISIBLE;
		cfg_data <= c.first_visible_line;
		@(posedge clk);
		cfg_index <= REG_LAST_VISIBLE;
		cfg_data <= c.last_visible_line;
		@(posedge clk);
		cfg_index <= REG_DMA_START;
		cfg_data <= c.dma_start_line;
		@(posedge clk);
		cfg_index <= REG_IDLE_SELECT;
		cfg_data <= {8'($urandom), c.idle_source_select};
		@(posedge clk);
		cfg_write_enable <= 1'b0;
		cfg_now = c;
		settings_used++;
	endtask

	// Register setting for one random phase: the reset values, a one-line
	// band at the top, an inverted band, or a random band.
	function automatic cfg_t pick_setting(input int phase);
		cfg_t c;
		c.idle_source_select = 1'($urandom);
		case (phase)
			0: begin
				c.first_visible_line = FIRST_VISIBLE_RST;
				c.last_visible_line = LAST_VISIBLE_RST;
				c.dma_start_line = DMA_START_RST;
			end
			1: begin
				c.first_visible_line = '1;
				c.last_visible_line = '1;
				c.dma_start_line = '1;
			end
			2: begin
				c.first_visible_line = 9'($urandom_range(256, 511));
				c.last_visible_line = 9'($urandom_range(0, 255));
				c.dma_start_line = 9'($urandom);
			end
			default: begin
				c.first_visible_line = 9'($urandom_range(0, 200));
				c.last_visible_line = 9'($urandom_range(c.first_visible_line, 511));
				c.dma_start_line = $urandom_range(0, 1) ?
					9'($urandom_range(c.first_visible_line, c.last_visible_line)) :
					9'($urandom);
			end
		endcase
		return c;
	endfunction

	// Mostly consecutive lines with frequent frame starts, some jumps to the
	// band edges and the DMA line, and some arbitrary lines.
	function automatic item_t random_line(input logic [LINE_W-1:0] prev);
		item_t ev;
		int    pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			ev.line_number = '0;
		else if (pick < 20) begin
			case ($urandom_range(0, 4))
				0: ev.line_number = cfg_now.first_visible_line - LINE_W'(1);
				1: ev.line_number = cfg_now.first_visible_line;
				2: ev.line_number = cfg_now.last_visible_line;
				3: ev.line_number = cfg_now.last_visible_line + LINE_W'(1);
				default: ev.line_number = cfg_now.dma_start_line;
			endcase
		end else if (pick < 28)
			ev.line_number = 9'($urandom);
		else
			ev.line_number = prev + LINE_W'(1);
		ev.bad_line_seen = ($urandom_range(0, 7) == 0);
		ev.display_blanked = 1'($urandom);
		ev.force_display = ($urandom_range(0, 15) == 0);
		ev.idle_byte_low_bank = 8'($urandom);
		ev.idle_byte_high_bank = 8'($urandom);
		return ev;
	endfunction

	// Reports one field that differs from its prediction.
	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endtask

	// Output stall comes in random bursts between low runs of varying length,
	// and stays low in the final phase.
	always @(posedge clk) begin : result_stall
		int hold_left;
		int run_left;
		if (calm || !arst_n)
			out_stall <= 1'b0;
		else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (run_left > 0) begin
			out_stall <= 1'b0;
			run_left = run_left - 1;
		end else begin
			out_stall <= 1'b1;
			hold_left = $urandom_range(0, 15);
			run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
				$urandom_range(1, 24);
		end
	end

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no event outstanding");
				failures++;
			end else begin
				want = expected_results.pop_front();
				compare_field("matrix_counter", 16'(want.matrix_counter),
					16'(matrix_counter));
				compare_field("row_pointer", 16'(want.row_pointer), 16'(row_pointer));
				compare_field("colour_pointer", 16'(want.colour_pointer),
					16'(colour_pointer));
				compare_field("row_counter", 16'(want.row_counter), 16'(row_counter));
				compare_field("idle_flag", 16'(want.idle_flag), 16'(idle_flag));
				compare_field("cursor_on", 16'(want.cursor_on), 16'(cursor_on));
				compare_field("bad_lines_allowed", 16'(want.bad_lines_allowed),
					16'(bad_lines_allowed));
				compare_field("idle_source", 16'(want.idle_source), 16'(idle_source));
				compare_field("idle_byte", 16'(want.idle_byte), 16'(idle_byte));
				compare_field("frame_start", 16'(want.frame_start), 16'(frame_start));
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Reset, the directed table, then random phases under fresh settings.
	initial begin : stimulus
		item_t             ev;
		logic [LINE_W-1:0] prev_line;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			if (directed_lines[i].setting != cfg_now) begin
				settle();
				apply_setting(directed_lines[i].setting);
			end
			send_line(directed_lines[i].line_in, directed_lines[i].typed,
				directed_lines[i].want);
		end

		prev_line = '0;
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			apply_setting(pick_setting(phase));
			calm = (phase == PHASES - 1);
			for (int n = 0; n < LINES_PER_PHASE; n++) begin
				if (!calm && $urandom_range(0, 7) == 0)
					pause_input($urandom_range(1, 16));
				ev = random_line(prev_line);
				prev_line = ev.line_number;
				send_line(ev, 1'b0, NO_RESULT);
			end
		end

		// Drain, then watch a little longer for stray results.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d line events (%0d from the table) under %0d register settings.",
			lines_sent, DIRECTED_COUNT, settings_used);
		$display("The predicted results held %0d frame starts and %0d idle lines.",
			frames_seen, idle_results);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
